/* rtl/core/lesq_pkg.sv */
// shared types, constants and a width helper for the largest empty square scan
`default_nettype none

package lesq_pkg;

    localparam int ROW_WIDTH_W = 11;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    // one cell on its way from the read stage to the scoring stage
    typedef struct packed {
        logic valid;
        logic free_cell;
        logic last;
        logic first_row;
        logic first_col;
        logic fwd;
    } cell_ctl_t;

    // index width for a count of n entries, never below one bit
    function automatic int idx_w(input int n);
        int w;
        w = (n > 1) ? $clog2(n) : 1;
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lesq_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module lesq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lesq_front.sv */
// read stage: raster counters, line buffer clearing pass, read issue and forwarding
`default_nettype none

module lesq_front
    import lesq_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [ROW_WIDTH_W-1:0]            row_width,
    input  wire logic                              s_valid,
    input  wire logic                              s_free_cell,
    input  wire logic                              s_end_of_frame,
    output logic                                   s_ready,
    input  wire logic                              hold,
    input  wire logic                              wb_en,
    input  wire logic [idx_w(MAX_COLS)-1:0]        wb_addr,
    input  wire logic [$clog2(MAX_COLS+1)-1:0]     wb_data,
    output logic                                   ram_rd_en,
    output logic      [idx_w(MAX_COLS)-1:0]        ram_rd_addr,
    output logic                                   ram_wr_en,
    output logic      [idx_w(MAX_COLS)-1:0]        ram_wr_addr,
    output logic      [$clog2(MAX_COLS+1)-1:0]     ram_wr_data,
    output cell_ctl_t                              cell_ctl,
    output logic      [idx_w(MAX_COLS)-1:0]        cell_col,
    output logic      [idx_w(MAX_ROWS)-1:0]        cell_row,
    output logic      [$clog2(MAX_COLS+1)-1:0]     fwd_data
);

    localparam int COL_W  = idx_w(MAX_COLS);
    localparam int ROW_W  = idx_w(MAX_ROWS);
    localparam int SIZE_W = $clog2(MAX_COLS + 1);
    localparam int WID_W  = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
    localparam logic [WID_W-1:0] WID_MAX  = WID_W'(MAX_COLS);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  clr_addr_reg;
    logic              cleared_reg;
    cell_ctl_t         ctl_reg, ctl_next;
    logic [COL_W-1:0]  cell_col_reg;
    logic [ROW_W-1:0]  cell_row_reg;
    logic [SIZE_W-1:0] fwd_data_reg;
    logic [WID_W-1:0]  eff_width;
    logic [WID_W-1:0]  col_inc;
    logic              accept;

    assign s_ready = cleared_reg && !hold;
    assign accept  = s_valid && s_ready;

    // zero acts as one, anything past the line buffer acts as its depth
    always_comb begin
        if (row_width == '0) begin
            eff_width = WID_W'(1);
        end else if (WID_W'(row_width) > WID_MAX) begin
            eff_width = WID_MAX;
        end else begin
            eff_width = WID_W'(row_width);
        end
    end

    assign col_inc = WID_W'(col_reg) + WID_W'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (s_end_of_frame) begin
                col_next = '0;
                row_next = '0;
            end else if (col_inc >= eff_width) begin
                col_next = '0;
                if (row_reg != ROW_LAST) begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // the scoring stage writes the same entry at the edge this read samples it
    always_comb begin
        ctl_next.valid     = accept;
        ctl_next.free_cell = s_free_cell;
        ctl_next.last      = s_end_of_frame;
        ctl_next.first_row = (row_reg == '0);
        ctl_next.first_col = (col_reg == '0);
        ctl_next.fwd       = wb_en && (wb_addr == col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            clr_addr_reg <= '0;
            cleared_reg  <= 1'b0;
            ctl_reg      <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (!cleared_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == COL_LAST) begin
                    cleared_reg <= 1'b1;
                end
            end
            if (!hold) begin
                ctl_reg <= ctl_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!hold) begin
            cell_col_reg <= col_reg;
            cell_row_reg <= row_reg;
            fwd_data_reg <= wb_data;
        end
    end

    assign ram_rd_en   = accept;
    assign ram_rd_addr = col_reg;
    assign ram_wr_en   = !cleared_reg || wb_en;
    assign ram_wr_addr = cleared_reg ? wb_addr : clr_addr_reg;
    assign ram_wr_data = cleared_reg ? wb_data : '0;

    assign cell_ctl = ctl_reg;
    assign cell_col = cell_col_reg;
    assign cell_row = cell_row_reg;
    assign fwd_data = fwd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/lesq_score.sv */
// scoring stage: three-way min, line write-back, best tracking and result register
`default_nettype none

module lesq_score
    import lesq_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cell_ctl_t                         cell_ctl,
    input  wire logic [idx_w(MAX_COLS)-1:0]        cell_col,
    input  wire logic [idx_w(MAX_ROWS)-1:0]        cell_row,
    input  wire logic [$clog2(MAX_COLS+1)-1:0]     rd_data,
    input  wire logic [$clog2(MAX_COLS+1)-1:0]     fwd_data,
    output logic                                   hold,
    output logic                                   wb_en,
    output logic      [idx_w(MAX_COLS)-1:0]        wb_addr,
    output logic      [$clog2(MAX_COLS+1)-1:0]     wb_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_found,
    output logic      [$clog2(MAX_COLS+1)-1:0]     m_best_size,
    output logic      [idx_w(MAX_ROWS)-1:0]        m_best_row,
    output logic      [idx_w(MAX_COLS)-1:0]        m_best_col
);

    localparam int COL_W  = idx_w(MAX_COLS);
    localparam int ROW_W  = idx_w(MAX_ROWS);
    localparam int SIZE_W = $clog2(MAX_COLS + 1);

    logic [SIZE_W-1:0] left_reg;
    logic [SIZE_W-1:0] upper_left_reg;
    logic [SIZE_W-1:0] best_score_reg, best_score_next;
    logic [ROW_W-1:0]  best_row_reg, best_row_next;
    logic [COL_W-1:0]  best_col_reg, best_col_next;
    logic              m_valid_reg;
    logic              m_found_reg;
    logic [SIZE_W-1:0] m_size_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [COL_W-1:0]  m_col_reg;
    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] min_lu;
    logic [SIZE_W-1:0] min_all;
    logic [SIZE_W-1:0] score;

    // a frame-end cell waits here while the previous result is still unread
    assign hold  = cell_ctl.valid && cell_ctl.last && m_valid_reg && !m_ready;
    assign wb_en = cell_ctl.valid && !hold;

    assign up      = cell_ctl.fwd ? fwd_data : rd_data;
    assign min_lu  = (left_reg < up) ? left_reg : up;
    assign min_all = (min_lu < upper_left_reg) ? min_lu : upper_left_reg;

    always_comb begin
        if (!cell_ctl.free_cell) begin
            score = '0;
        end else if (cell_ctl.first_row || cell_ctl.first_col) begin
            score = SIZE_W'(1);
        end else begin
            score = min_all + SIZE_W'(1);
        end
    end

    // strict compare keeps the first of equal scores
    always_comb begin
        best_score_next = best_score_reg;
        best_row_next   = best_row_reg;
        best_col_next   = best_col_reg;
        if (score > best_score_reg) begin
            best_score_next = score;
            best_row_next   = cell_row;
            best_col_next   = cell_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg       <= '0;
            upper_left_reg <= '0;
            best_score_reg <= '0;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (wb_en) begin
                if (cell_ctl.last) begin
                    left_reg       <= '0;
                    upper_left_reg <= '0;
                    best_score_reg <= '0;
                    best_row_reg   <= '0;
                    best_col_reg   <= '0;
                end else begin
                    left_reg       <= score;
                    upper_left_reg <= up;
                    best_score_reg <= best_score_next;
                    best_row_reg   <= best_row_next;
                    best_col_reg   <= best_col_next;
                end
            end
            if (wb_en && cell_ctl.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wb_en && cell_ctl.last) begin
            m_found_reg <= (best_score_next != '0);
            m_size_reg  <= best_score_next;
            m_row_reg   <= best_row_next;
            m_col_reg   <= best_col_next;
        end
    end

    assign wb_addr     = cell_col;
    assign wb_data     = score;
    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_best_size = m_size_reg;
    assign m_best_row  = m_row_reg;
    assign m_best_col  = m_col_reg;

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cell_ctl.valid && cell_ctl.last))
        else $error("result raised without a frame-end cell");

    a_found_matches_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_found_reg == (m_size_reg != '0)))
        else $error("found flag disagrees with best size");

    a_best_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (wb_en && !cell_ctl.last) |=> (best_score_reg >= $past(best_score_reg)))
        else $error("best score dropped inside a frame");

    a_score_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (wb_en && cell_ctl.free_cell && !cell_ctl.first_row && !cell_ctl.first_col)
            |-> ({1'b0, score} <= {1'b0, left_reg} + 1'b1))
        else $error("score exceeds left neighbor plus one");

    a_no_load_over_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_size_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

/* rtl/core/largest_empty_square_scan.sv */
// Largest empty square scan over a raster stream of grid cells.
//
// Cells arrive on the s_ channel (s_valid/s_ready), one request per cell in
// raster order; s_end_of_frame marks the grid's last cell. The row width is
// written through cfg_wr_en/cfg_wr_data while the block is idle; 0 acts as 1.
// One result per frame leaves on the m_ channel (m_valid/m_ready): found, the
// side of the largest all-free square and its bottom-right row and column,
// the first such square in raster order on ties.
// Throughput is one cell per clock while s_ready is high, set by the single
// line buffer ram: each cell reads its column in the read stage and writes
// its score back in the scoring stage, forwarded when the next cell reads that
// same column. m_valid is registered when the frame's last cell is written
// back. After reset a clearing pass zeroes all MAX_COLS line buffer entries
// with s_ready low; configuration writes are taken during it.
// While a result waits on m_ready, cells keep flowing; a following frame-end
// cell waits in the scoring stage and s_ready drops until the result is taken.
`default_nettype none

module largest_empty_square_scan
    import lesq_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ROW_WIDTH_W-1:0]            cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_free_cell,
    input  wire logic                              s_end_of_frame,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_found,
    output logic      [$clog2(MAX_COLS+1)-1:0]     m_best_size,
    output logic      [idx_w(MAX_ROWS)-1:0]        m_best_row,
    output logic      [idx_w(MAX_COLS)-1:0]        m_best_col
);

    localparam int COL_W  = idx_w(MAX_COLS);
    localparam int ROW_W  = idx_w(MAX_ROWS);
    localparam int SIZE_W = $clog2(MAX_COLS + 1);

    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic                   hold;
    logic                   wb_en;
    logic [COL_W-1:0]       wb_addr;
    logic [SIZE_W-1:0]      wb_data;
    logic                   ram_rd_en;
    logic [COL_W-1:0]       ram_rd_addr;
    logic [SIZE_W-1:0]      ram_rd_data;
    logic                   ram_wr_en;
    logic [COL_W-1:0]       ram_wr_addr;
    logic [SIZE_W-1:0]      ram_wr_data;
    cell_ctl_t              cell_ctl;
    logic [COL_W-1:0]       cell_col;
    logic [ROW_W-1:0]       cell_row;
    logic [SIZE_W-1:0]      fwd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            row_width_reg <= cfg_wr_data;
        end
    end

    lesq_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .row_width      (row_width_reg),
        .s_valid        (s_valid),
        .s_free_cell    (s_free_cell),
        .s_end_of_frame (s_end_of_frame),
        .s_ready        (s_ready),
        .hold           (hold),
        .wb_en          (wb_en),
        .wb_addr        (wb_addr),
        .wb_data        (wb_data),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .cell_ctl       (cell_ctl),
        .cell_col       (cell_col),
        .cell_row       (cell_row),
        .fwd_data       (fwd_data)
    );

    lesq_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lesq_score #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_score (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cell_ctl    (cell_ctl),
        .cell_col    (cell_col),
        .cell_row    (cell_row),
        .rd_data     (ram_rd_data),
        .fwd_data    (fwd_data),
        .hold        (hold),
        .wb_en       (wb_en),
        .wb_addr     (wb_addr),
        .wb_data     (wb_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_best_size (m_best_size),
        .m_best_row  (m_best_row),
        .m_best_col  (m_best_col)
    );

endmodule

`default_nettype wire

/* tb/sv/largest_empty_square_scan_tb.sv */
// testbench for largest_empty_square_scan: directed and random raster frames checked against a score predictor
module largest_empty_square_scan_tb
    import lesq_pkg::*;
();

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int QUIET_LIMIT = 20000;
    localparam int RANDOM_CELLS = 300;

    typedef struct {
        logic is_free;
        logic is_last;
    } cell_t;

    typedef struct {
        logic        found;
        logic [10:0] size;
        logic [9:0]  row;
        logic [9:0]  col;
    } square_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [ROW_WIDTH_W-1:0] cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_free_cell = 1'b0;
    logic                   s_end_of_frame = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_found;
    logic [10:0]            m_best_size;
    logic [9:0]             m_best_row;
    logic [9:0]             m_best_col;

    // predictor state
    logic [ROW_WIDTH_W-1:0] row_width_q = ROW_WIDTH_RESET;
    logic [10:0]            upper_scores [MAX_COLS] = '{default: '0};
    logic [10:0]            left_sc = '0;
    logic [10:0]            upleft_sc = '0;
    logic [9:0]             col_pos = '0;
    logic [9:0]             row_pos = '0;
    logic [10:0]            top_size = '0;
    logic [9:0]             top_row = '0;
    logic [9:0]             top_col = '0;

    cell_t          pending_cells[$];
    square_result_t expected_squares[$];
    int             cells_queued = 0;
    int             mismatches = 0;
    int             quiet_cycles = 0;
    bit             no_gaps = 1'b0;

    largest_empty_square_scan #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_free_cell    (s_free_cell),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_best_size    (m_best_size),
        .m_best_row     (m_best_row),
        .m_best_col     (m_best_col)
    );

    always #1 aclk = ~aclk;

    function automatic int active_width();
        if (row_width_q == 0) return 1;
        if (row_width_q > MAX_COLS) return MAX_COLS;
        return int'(row_width_q);
    endfunction

    function automatic void score_cell(input logic is_free, input logic is_last);
        int             span;
        logic [10:0]    up;
        logic [10:0]    score;
        logic [10:0]    low;
        square_result_t res;
        span = active_width();
        up = upper_scores[col_pos];
        if (!is_free) begin
            score = '0;
        end else if (row_pos == 0 || col_pos == 0) begin
            score = 11'd1;
        end else begin
            low = (left_sc < up) ? left_sc : up;
            if (upleft_sc < low) low = upleft_sc;
            score = low + 11'd1;
        end
        upper_scores[col_pos] = score;
        upleft_sc = up;
        left_sc = score;
        // strict compare keeps the first square on ties
        if (score > top_size) begin
            top_size = score;
            top_row = row_pos;
            top_col = col_pos;
        end
        if (int'(col_pos) + 1 >= span) begin
            col_pos = '0;
            // row counter saturates on very tall frames
            if (int'(row_pos) + 1 < MAX_ROWS) row_pos = row_pos + 10'd1;
        end else begin
            col_pos = col_pos + 10'd1;
        end
        if (is_last) begin
            res.found = (top_size != 0);
            res.size = top_size;
            res.row = top_row;
            res.col = top_col;
            expected_squares.push_back(res);
            left_sc = '0;
            upleft_sc = '0;
            col_pos = '0;
            row_pos = '0;
            top_size = '0;
            top_row = '0;
            top_col = '0;
        end
    endfunction

    always @(posedge aclk) begin : cell_driver
        cell_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) score_cell(s_free_cell, s_end_of_frame);
            if (!s_valid || s_ready) begin
                if (pending_cells.size() != 0 && (no_gaps || $urandom_range(99) >= 8)) begin
                    c = pending_cells.pop_front();
                    s_valid <= 1'b1;
                    s_free_cell <= c.is_free;
                    s_end_of_frame <= c.is_last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_check
        square_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_squares.size() == 0) begin
                    $error("result request with no frame end pending");
                    mismatches++;
                end else begin
                    want = expected_squares.pop_front();
                    if (m_found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, m_found);
                        mismatches++;
                    end
                    if (m_best_size !== want.size) begin
                        $error("best_size: expected %0d, got %0d", want.size, m_best_size);
                        mismatches++;
                    end
                    if (m_best_row !== want.row) begin
                        $error("best_row: expected %0d, got %0d", want.row, m_best_row);
                        mismatches++;
                    end
                    if (m_best_col !== want.col) begin
                        $error("best_col: expected %0d, got %0d", want.col, m_best_col);
                        mismatches++;
                    end
                end
            end
            m_ready <= no_gaps || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("largest_empty_square_scan_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic void queue_cell(input logic is_free, input logic is_last);
        cell_t c;
        c.is_free = is_free;
        c.is_last = is_last;
        pending_cells.push_back(c);
        cells_queued++;
    endfunction

    // first cell of the frame is the msb
    function automatic void queue_pattern(input logic [15:0] bits, input int n);
        for (int i = 0; i < n; i++) queue_cell(bits[n-1-i], i == n - 1);
    endfunction

    function automatic void queue_cells(input int n, input int free_pct, input bit ends_frame);
        for (int i = 0; i < n; i++)
            queue_cell($urandom_range(99) < free_pct, ends_frame && i == n - 1);
    endfunction

    function automatic logic [ROW_WIDTH_W-1:0] pick_width();
        int r;
        r = $urandom_range(99);
        if (r < 6) return '0;
        if (r < 10) return ROW_WIDTH_W'(1024 + $urandom_range(1023));
        if (r < 16) return ROW_WIDTH_W'($urandom_range(64, 17));
        return ROW_WIDTH_W'($urandom_range(16, 1));
    endfunction

    // block drained: no request in flight, no result owed, pipeline flushed
    task automatic drain(input int extra);
        while (pending_cells.size() != 0 || s_valid || expected_squares.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_row_width(input logic [ROW_WIDTH_W-1:0] w);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        row_width_q = w;
    endtask

    initial begin
        int target;
        int kind;
        int n;
        int part;
        int pct;
        int span;
        int r;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset width, tie in the first row
        queue_pattern(16'b011, 3);
        drain(8);
        // zero width acts as one column
        write_row_width(11'd0);
        queue_pattern(16'b111, 3);
        queue_pattern(16'b00, 2);
        drain(8);
        write_row_width(11'd2);
        queue_pattern(16'b1111, 4);
        queue_pattern(16'b0, 1);
        queue_pattern(16'b1, 1);
        drain(8);
        // 3x3 with two size-2 squares, the first must win
        write_row_width(11'd3);
        queue_pattern(16'b110_111_011, 9);

        // tall frame: row counter saturates, then the width widens mid-frame
        drain(8);
        write_row_width(11'd1);
        queue_cells(1026, 0, 1'b0);
        drain(8);
        write_row_width(11'd3);
        queue_cells(12, 85, 1'b1);

        // oversized width clamps to the line length, run with no gaps
        drain(8);
        write_row_width(11'd2047);
        no_gaps = 1'b1;
        queue_cells(1030, 90, 1'b1);
        drain(0);
        no_gaps = 1'b0;

        target = cells_queued + RANDOM_CELLS;
        while (cells_queued < target) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                drain(8);
                write_row_width(pick_width());
            end
            span = active_width();
            r = $urandom_range(99);
            pct = (r < 5) ? 0 : (r < 12) ? 100 : 55 + $urandom_range(40);
            if (span <= 64 && $urandom_range(99) < 85)
                n = span * $urandom_range((span <= 16) ? 8 : 2, 1);
            else
                n = $urandom_range(40, 1);
            if (kind == 9 && n > 1) begin
                // width change in the middle of a frame
                part = $urandom_range(n - 1, 1);
                queue_cells(part, pct, 1'b0);
                drain(8);
                write_row_width(pick_width());
                queue_cells(n - part, pct, 1'b1);
            end else begin
                queue_cells(n, pct, 1'b1);
            end
        end

        drain(10);
        if (mismatches == 0) begin
            $display("largest_empty_square_scan_tb OK");
        end else begin
            $display("largest_empty_square_scan_tb NOT OK");
        end
        $finish;
    end

endmodule
